>>> rtl/cgd_pkg.sv
// Shared types and constants for the CTC greedy decoder.
`timescale 1ns / 1ps
package cgd_pkg;

  localparam int MAX_CLASSES = 128;
  localparam int POS_W       = $clog2(MAX_CLASSES);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int DIV_W       = 64;

  localparam logic [7:0]  NC_RESET  = 8'd128;
  localparam logic [7:0]  NC_MIN    = 8'd2;
  localparam logic [7:0]  NC_MAX    = 8'(MAX_CLASSES);
  localparam logic [23:0] ONE_Q16   = 24'd65536;
  localparam logic [23:0] ACC_MAX   = 24'hFFFFFF;
  localparam logic [16:0] EXP_LIMIT = 17'd3072;
  localparam logic [7:0]  NO_WINNER = 8'hFF;
  localparam logic [15:0] KEPT_MAX  = 16'hFFFF;
  localparam logic [7:0]  TERM_CAP  = 8'd199;

  typedef enum logic {
    KIND_LABEL   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [15:0] logit;
    logic               fin;
    logic               first;
    logic               row_end;
    logic [POS_W-1:0]   pos;
  } cgd_item_t;

endpackage

>>> rtl/cgd_front.sv
// Front end: class register, class counter and item tagging.
`timescale 1ns / 1ps
module cgd_front
  import cgd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] logit,
  input  logic               final_step,
  input  logic               q_full,
  output logic               q_push,
  output cgd_item_t          q_item
);

  logic [7:0]       num_classes;
  logic [7:0]       classes;
  logic [POS_W-1:0] limit;
  logic [POS_W-1:0] pos;
  logic             row_end;

  always_comb begin
    classes = num_classes;
    if (classes < NC_MIN) classes = NC_MIN;
    if (classes > NC_MAX) classes = NC_MAX;
  end

  assign limit    = POS_W'(classes - 8'd1);
  assign row_end  = (pos >= limit);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.logit   = logit;
    q_item.fin     = final_step;
    q_item.first   = (pos == '0);
    q_item.row_end = row_end;
    q_item.pos     = pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes <= NC_RESET;
      pos         <= '0;
    end else begin
      if (cfg_write) num_classes <= cfg_data;
      if (q_push) pos <= row_end ? '0 : pos + POS_W'(1);
    end
  end

endmodule

>>> rtl/cgd_fifo.sv
// Short item queue between front and back.
`timescale 1ns / 1ps
module cgd_fifo
  import cgd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cgd_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output cgd_item_t pop_item
);

  cgd_item_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

>>> rtl/cgd_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module cgd_div
  import cgd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DIV_W:0]   shifted;
  logic             fits;

  assign shifted  = {rem[DIV_W-1:0], quo[DIV_W-1]};
  assign fits     = (shifted >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? shifted - {1'b0, dvs} : shifted;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt  <= cnt - CNT_W'(1);
        busy <= (cnt != CNT_W'(1));
      end
    end
  end

endmodule

>>> rtl/cgd_back.sv
// Back end: online softmax, exponential series, row decision and results.
`timescale 1ns / 1ps
module cgd_back
  import cgd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_pop,
  input  cgd_item_t        q_item,
  output logic             div_start,
  output logic [DIV_W-1:0] div_dividend,
  output logic [DIV_W-1:0] div_divisor,
  input  logic             div_done,
  input  logic [DIV_W-1:0] div_quotient,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             kind,
  output logic [6:0]       label,
  output logic [16:0]      label_confidence,
  output logic [16:0]      mean_confidence,
  output logic [15:0]      kept_count,
  output logic             last
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_TERM_GO, S_TERM_WAIT, S_EXP_GO, S_EXP_WAIT, S_APPLY,
    S_RESCALE, S_PROB_GO, S_PROB_WAIT, S_DECIDE, S_LABEL, S_MEAN_GO,
    S_MEAN_WAIT, S_SUM
  } state_t;

  state_t             state;
  cgd_item_t          cur;
  logic signed [15:0] row_maximum;
  logic [POS_W-1:0]   row_best_class;
  logic [23:0]        exp_accumulator;
  logic [7:0]         previous_winner;
  logic [32:0]        probability_total;
  logic [15:0]        labels_kept;
  logic               rise;
  logic [11:0]        delta;
  logic [49:0]        term;
  logic [51:0]        series;
  logic [61:0]        prod;
  logic [3:0]         mcnt;
  logic [7:0]         k;
  logic [16:0]        exp_val;
  logic [40:0]        mprod;
  logic [16:0]        prob;

  logic signed [16:0] diff;
  logic               rise_in;
  logic [16:0]        dist_in;
  logic               out_free;
  logic [49:0]        term_q;
  logic [24:0]        acc_sum;
  logic [25:0]        acc_scaled;
  logic               keep;

  assign diff       = 17'(q_item.logit) - 17'(row_maximum);
  assign rise_in    = (q_item.logit > row_maximum);
  assign dist_in    = rise_in ? 17'(diff) : 17'(-diff);
  assign out_free   = !out_valid || out_ready;
  assign term_q     = div_quotient[49:0];
  assign acc_sum    = 25'(exp_accumulator) + 25'(exp_val);
  assign acc_scaled = 26'((mprod + 41'd32768) >> 16) + 26'(ONE_Q16);
  assign keep       = (row_best_class != '0) && (8'(row_best_class) != previous_winner);
  assign q_pop      = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      row_maximum       <= '0;
      row_best_class    <= '0;
      exp_accumulator   <= '0;
      previous_winner   <= NO_WINNER;
      probability_total <= '0;
      labels_kept       <= '0;
      div_start         <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            rise  <= rise_in;
            delta <= dist_in[11:0];
            if (q_item.first) begin
              row_maximum     <= q_item.logit;
              row_best_class  <= '0;
              exp_accumulator <= ONE_Q16;
              state           <= q_item.row_end ? S_PROB_GO : S_IDLE;
            end else if (dist_in >= EXP_LIMIT) begin
              exp_val <= '0;
              state   <= S_APPLY;
            end else begin
              term   <= 50'd1 << 32;
              series <= 52'd1 << 32;
              k      <= 8'd1;
              prod   <= '0;
              mcnt   <= '0;
              state  <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (delta[mcnt]) prod <= prod + ({12'd0, term} << mcnt);
          if (mcnt == 4'd11) state <= S_TERM_GO;
          else mcnt <= mcnt + 4'd1;
        end
        S_TERM_GO: begin
          div_start    <= 1'b1;
          div_dividend <= DIV_W'(prod >> 8);
          div_divisor  <= DIV_W'(k);
          state        <= S_TERM_WAIT;
        end
        S_TERM_WAIT: begin
          if (div_done) begin
            series <= series + 52'(term_q);
            if (term_q == '0 || k == TERM_CAP) begin
              state <= S_EXP_GO;
            end else begin
              term  <= term_q;
              k     <= k + 8'd1;
              prod  <= '0;
              mcnt  <= '0;
              state <= S_MUL;
            end
          end
        end
        S_EXP_GO: begin
          div_start    <= 1'b1;
          div_dividend <= (DIV_W'(1) << 48) + DIV_W'(series >> 1);
          div_divisor  <= DIV_W'(series);
          state        <= S_EXP_WAIT;
        end
        S_EXP_WAIT: begin
          if (div_done) begin
            exp_val <= div_quotient[16:0];
            state   <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (rise) begin
            mprod <= exp_accumulator * exp_val;
            state <= S_RESCALE;
          end else begin
            exp_accumulator <= (acc_sum > 25'(ACC_MAX)) ? ACC_MAX : acc_sum[23:0];
            state           <= cur.row_end ? S_PROB_GO : S_IDLE;
          end
        end
        S_RESCALE: begin
          exp_accumulator <= (acc_scaled > 26'(ACC_MAX)) ? ACC_MAX : acc_scaled[23:0];
          row_maximum     <= cur.logit;
          row_best_class  <= cur.pos;
          state           <= cur.row_end ? S_PROB_GO : S_IDLE;
        end
        S_PROB_GO: begin
          div_start    <= 1'b1;
          div_dividend <= (DIV_W'(1) << 32) + DIV_W'(exp_accumulator >> 1);
          div_divisor  <= (exp_accumulator == '0) ? DIV_W'(1) : DIV_W'(exp_accumulator);
          state        <= S_PROB_WAIT;
        end
        S_PROB_WAIT: begin
          if (div_done) begin
            prob  <= div_quotient[16:0];
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (keep) begin
            state <= S_LABEL;
          end else begin
            previous_winner <= 8'(row_best_class);
            state           <= cur.fin ? S_MEAN_GO : S_IDLE;
          end
        end
        S_LABEL: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            kind             <= KIND_LABEL;
            label            <= 7'(row_best_class - POS_W'(1));
            label_confidence <= prob;
            mean_confidence  <= '0;
            kept_count       <= '0;
            last             <= 1'b0;
            if (labels_kept != KEPT_MAX) begin
              labels_kept       <= labels_kept + 16'd1;
              probability_total <= probability_total + 33'(prob);
            end
            previous_winner <= 8'(row_best_class);
            state           <= cur.fin ? S_MEAN_GO : S_IDLE;
          end
        end
        S_MEAN_GO: begin
          if (labels_kept == '0) begin
            prob  <= '0;
            state <= S_SUM;
          end else begin
            div_start    <= 1'b1;
            div_dividend <= DIV_W'(probability_total) + DIV_W'(labels_kept >> 1);
            div_divisor  <= DIV_W'(labels_kept);
            state        <= S_MEAN_WAIT;
          end
        end
        S_MEAN_WAIT: begin
          if (div_done) begin
            prob  <= div_quotient[16:0];
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            kind              <= KIND_SUMMARY;
            label             <= '0;
            label_confidence  <= '0;
            mean_confidence   <= prob;
            kept_count        <= labels_kept;
            last              <= 1'b1;
            previous_winner   <= NO_WINNER;
            probability_total <= '0;
            labels_kept       <= '0;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/ctc_greedy_decoder.sv
// Top level of the CTC greedy decoder: front end, item queue, back end, divider.
`timescale 1ns / 1ps
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_ready   logit, final_step
//  result    out        out_valid / out_ready kind, label, label_confidence,
//                                             mean_confidence, kept_count, last
//  config    in         cfg_write             cfg_data (num_classes)
//
//  Work: the back end takes the first logit of a row in its idle state without
//  an exp; a logit 12.0 or more below or above the running max skips the series.
//  Others run an exp series on the shared divider, one division per series term
//  after a shift-add multiply, up to 199 terms, plus one division for the final
//  reciprocal. Row end adds a division for 1/sum; a final row adds one more for
//  the mean when any label was kept.
//  Reset: rst is synchronous; it clears all sequence state, num_classes to 128.
//  Stalls: a held result stalls the back end only; the 2-entry queue keeps
//  taking items until it fills.
module ctc_greedy_decoder
  import cgd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] logit,
  input  logic               final_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [6:0]         label,
  output logic [16:0]        label_confidence,
  output logic [16:0]        mean_confidence,
  output logic [15:0]        kept_count,
  output logic               last
);

  // Front to queue.
  logic      q_full;
  logic      q_push;
  cgd_item_t q_in;

  // Queue to back.
  logic      q_pop;
  logic      q_valid;
  cgd_item_t q_out;

  // Shared divider.
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quotient;

  // Tag each logit with its place in the row.
  cgd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .logit      (logit),
    .final_step (final_step),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_in)
  );

  // Hold tagged items while the back end works.
  cgd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_out)
  );

  // Run the softmax and emit results.
  cgd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_item           (q_out),
    .div_start        (div_start),
    .div_dividend     (div_dividend),
    .div_divisor      (div_divisor),
    .div_done         (div_done),
    .div_quotient     (div_quotient),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .label            (label),
    .label_confidence (label_confidence),
    .mean_confidence  (mean_confidence),
    .kept_count       (kept_count),
    .last             (last)
  );

  // Serve every division of the back end.
  cgd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

>>> rtl/cgd_checker.sv
// Port-level checks for the CTC greedy decoder, bound to the top level.
`timescale 1ns / 1ps
module cgd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic [6:0]  label,
  input logic [16:0] label_confidence,
  input logic [16:0] mean_confidence,
  input logic [15:0] kept_count,
  input logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(label) && $stable(kind))
    else $error("result dropped or changed while stalled");

  a_kind_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == last))
    else $error("summary flag disagrees with kind");

  a_label_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> (mean_confidence == '0) && (kept_count == '0))
    else $error("label item carries summary fields");

  a_summary_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> (label == '0) && (label_confidence == '0)
      && (mean_confidence <= 17'd65536))
    else $error("summary item fields out of range");

  a_conf_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> (label_confidence <= 17'd65536))
    else $error("label probability above one");

endmodule

bind ctc_greedy_decoder cgd_checker u_cgd_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .kind             (kind),
  .label            (label),
  .label_confidence (label_confidence),
  .mean_confidence  (mean_confidence),
  .kept_count       (kept_count),
  .last             (last)
);
